>>> design/sqg_pkg.sv
// Shared types and constants for the SOGI quadrature generator.
// No dependencies; imported by sqg_mac and the top level.
package sqg_pkg;

	localparam int COEF_W      = 32;   // Q2.x coefficient registers
	localparam int HIST_W      = 40;   // history word width
	localparam int RESULT_W    = 16;   // result width
	localparam int CHUNK_W     = 20;   // multiplier operand B slice
	localparam int OPER_W      = 64;   // B operand before slicing
	localparam int CFG_INDEX_W = 2;

	localparam logic signed [COEF_W-1:0] RST_GAIN_B0       = 32'sd5897527;
	localparam logic signed [COEF_W-1:0] RST_FEEDBACK_A1   = 32'sd1061828659;
	localparam logic signed [COEF_W-1:0] RST_FEEDBACK_A2   = -32'sd530444567;
	localparam logic signed [COEF_W-1:0] RST_HALF_OMEGA_TS = 32'sd4216587;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_GAIN_B0       = 2'd0,
		CFG_FEEDBACK_A1   = 2'd1,
		CFG_FEEDBACK_A2   = 2'd2,
		CFG_HALF_OMEGA_TS = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// product terms in issue order
	typedef enum logic [2:0] {
		T_LB,     // lamda * b0
		T_DIFF,   // b0 * (x0 - x2)
		T_A1I,    // a1 * a1h
		T_A2I,    // a2 * a2h
		T_A1Q,    // a1 * b1h
		T_A2Q,    // a2 * b2h
		T_SUMQ    // lb * (x0 + 2x1 + x2)
	} term_t;

	typedef enum logic [1:0] {
		SUM_LB,
		SUM_IP,
		SUM_QD
	} sum_t;

	typedef struct packed {
		logic       issue;
		logic       start;
		logic       last;
		logic [1:0] chunk;
		logic       scale;
		sum_t       tag;
	} mac_ctl_t;

	typedef struct packed {
		logic valid;
		sum_t tag;
	} mac_fin_t;

endpackage

>>> design/sqg_mac.sv
// Shared multiply-accumulate unit: 32x21 signed multiplier, shifting
// accumulator and round-to-history shifter. Depends on sqg_pkg.
module sqg_mac #(
	parameter int ACC_W           = 78,
	parameter int COEF_FRAC_BITS  = 29,
	parameter int STATE_FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sqg_pkg::mac_ctl_t                 ctl,
	input  logic signed [sqg_pkg::COEF_W-1:0] a_op,
	input  logic signed [sqg_pkg::CHUNK_W:0]  b_chunk,
	output sqg_pkg::mac_fin_t                 fin,
	output logic signed [ACC_W-1:0]           rnd
);
	import sqg_pkg::*;

	localparam int PROD_W = COEF_W + CHUNK_W + 1;
	localparam int SH_W   = 7;
	localparam logic signed [ACC_W-1:0] RND_HALF =
		{{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

	logic signed [PROD_W-1:0] prod_s1;
	mac_ctl_t                 ctl_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0]  base;
	logic [SH_W-1:0]          sh;
	mac_fin_t                 fin_q;

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			prod_s1 <= PROD_W'(a_op) * PROD_W'(b_chunk);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			fin_q  <= '0;
		end else begin
			ctl_s1    <= ctl;
			fin_q.valid <= ctl_s1.issue & ctl_s1.last;
			fin_q.tag   <= ctl_s1.tag;
		end
	end

	// slice k weighs 2^(20k); scaled terms carry the extra state fraction
	always_comb begin
		sh = SH_W'(CHUNK_W * int'(ctl_s1.chunk));
		if (ctl_s1.scale) begin
			sh = sh + SH_W'(STATE_FRAC_BITS);
		end
		addend = ACC_W'(prod_s1) <<< sh;
		base   = ctl_s1.start ? '0 : acc_q;
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.issue) begin
			acc_q <= base + addend;
		end
	end

	// round half up, drop coefficient fraction bits
	assign rnd = (acc_q + RND_HALF) >>> COEF_FRAC_BITS;
	assign fin = fin_q;

endmodule

>>> design/sogi_quadrature_generator_unit.sv
// SOGI quadrature generator top level: sequencer, history and I/O registers.
// Depends on sqg_pkg and sqg_mac.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  input   | in        | in_valid/in_stall  | sample
//  output  | out       | out_valid/out_stall| in_phase, quadrature
//  config  | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One sample takes 12 + LB_CHUNKS multiplier passes through the single shared
// 32x21 multiplier, then the accumulate and round stages, the load of the output
// register and a return to the idle state before the next transfer is taken.
// Reset loads the coefficient defaults and zeroes all history.
// in_stall is high from the accepted transfer until the result is loaded;
// a stalled output holds the next result back in the final state.
module sogi_quadrature_generator_unit #(
	parameter int SAMPLE_WIDTH    = 16,
	parameter int COEF_FRAC_BITS  = 29,
	parameter int STATE_FRAC_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [SAMPLE_WIDTH-1:0]                sample,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [sqg_pkg::RESULT_W-1:0]           in_phase,
	output logic [sqg_pkg::RESULT_W-1:0]           quadrature,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [sqg_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [sqg_pkg::COEF_W-1:0]             cfg_data
);
	import sqg_pkg::*;

	localparam int LB_W      = 64 - COEF_FRAC_BITS;
	localparam int LB_CHUNKS = (LB_W - 2) / CHUNK_W + 1;
	localparam int ACC_Q     = LB_W + SAMPLE_WIDTH + 3 + STATE_FRAC_BITS;
	localparam int ACC_H     = COEF_W + HIST_W + 2;
	localparam int ACC_W     = ((ACC_Q > ACC_H) ? ACC_Q : ACC_H) + 4;
	localparam int HIST_EXT_W = HIST_W + 1;
	localparam logic signed [HIST_EXT_W-1:0] RES_HALF =
		{{(HIST_EXT_W-1){1'b0}}, 1'b1} << (STATE_FRAC_BITS - 1);

	state_t state_q, state_d;
	term_t  term_q, term_next;
	logic [1:0] chunk_q;
	logic       chunk_last;
	logic       term_start, term_end, term_scale;
	sum_t       term_tag;

	logic signed [COEF_W-1:0] gain_b0_q, feedback_a1_q, feedback_a2_q, half_omega_ts_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_q, x1_q, x2_q;
	logic signed [HIST_W-1:0] hist_i1_q, hist_i2_q, hist_q1_q, hist_q2_q;
	logic signed [LB_W-1:0] lb_q;
	logic signed [SAMPLE_WIDTH:0]   diff;
	logic signed [SAMPLE_WIDTH+2:0] sum3;

	logic signed [COEF_W-1:0]  a_op;
	logic signed [OPER_W-1:0]  b_op, b_sh;
	logic signed [CHUNK_W:0]   b_chunk;
	mac_ctl_t                  ctl;
	mac_fin_t                  fin;
	logic signed [ACC_W-1:0]   rnd;
	logic signed [HIST_W-1:0]  hist_new;
	logic [ACC_W-HIST_W:0]     rnd_upper;

	logic                out_valid_q;
	logic [RESULT_W-1:0] in_phase_q, quadrature_q;
	logic                out_free;
	logic                in_xfer;

	function automatic logic [RESULT_W-1:0] to_result(input logic signed [HIST_W-1:0] h);
		logic signed [HIST_EXT_W-1:0] t;
		logic signed [HIST_EXT_W-1:0] q;
		t = HIST_EXT_W'(h) + RES_HALF;
		q = t >>> STATE_FRAC_BITS;
		if (&q[HIST_EXT_W-1:RESULT_W-1] || ~|q[HIST_EXT_W-1:RESULT_W-1]) begin
			return q[RESULT_W-1:0];
		end else if (q[HIST_EXT_W-1]) begin
			return {1'b1, {(RESULT_W-1){1'b0}}};
		end else begin
			return {1'b0, {(RESULT_W-1){1'b1}}};
		end
	endfunction

	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign in_phase  = in_phase_q;
	assign quadrature = quadrature_q;

	// term attributes and order
	always_comb begin
		term_start = 1'b0;
		term_end   = 1'b0;
		term_scale = 1'b0;
		term_tag   = SUM_IP;
		term_next  = T_LB;
		case (term_q)
			T_LB: begin
				term_start = 1'b1;
				term_end   = 1'b1;
				term_tag   = SUM_LB;
				term_next  = T_DIFF;
			end
			T_DIFF: begin
				term_start = 1'b1;
				term_scale = 1'b1;
				term_next  = T_A1I;
			end
			T_A1I: begin
				term_next = T_A2I;
			end
			T_A2I: begin
				term_end  = 1'b1;
				term_next = T_A1Q;
			end
			T_A1Q: begin
				term_start = 1'b1;
				term_tag   = SUM_QD;
				term_next  = T_A2Q;
			end
			T_A2Q: begin
				term_tag  = SUM_QD;
				term_next = T_SUMQ;
			end
			T_SUMQ: begin
				term_end   = 1'b1;
				term_scale = 1'b1;
				term_tag   = SUM_QD;
				term_next  = T_LB;
			end
			default: begin
				term_next = T_LB;
			end
		endcase
		if (term_q == T_SUMQ) begin
			chunk_last = (chunk_q == 2'(LB_CHUNKS - 1));
		end else begin
			chunk_last = (chunk_q == 2'd1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (term_q == T_SUMQ && chunk_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (fin.valid && fin.tag == SUM_QD) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		ctl.issue = (state_q == ST_RUN);
		ctl.start = term_start && (chunk_q == 2'd0);
		ctl.last  = term_end && chunk_last;
		ctl.chunk = chunk_q;
		ctl.scale = term_scale;
		ctl.tag   = term_tag;
	end

	// operand selection
	always_comb begin
		diff = (SAMPLE_WIDTH+1)'(sample_q) - (SAMPLE_WIDTH+1)'(x2_q);
		sum3 = (SAMPLE_WIDTH+3)'(sample_q) + ((SAMPLE_WIDTH+3)'(x1_q) <<< 1)
			+ (SAMPLE_WIDTH+3)'(x2_q);
		case (term_q)
			T_LB: begin
				a_op = half_omega_ts_q;
				b_op = OPER_W'(gain_b0_q);
			end
			T_DIFF: begin
				a_op = COEF_W'(diff);
				b_op = OPER_W'(gain_b0_q);
			end
			T_A1I: begin
				a_op = feedback_a1_q;
				b_op = OPER_W'(hist_i1_q);
			end
			T_A2I: begin
				a_op = feedback_a2_q;
				b_op = OPER_W'(hist_i2_q);
			end
			T_A1Q: begin
				a_op = feedback_a1_q;
				b_op = OPER_W'(hist_q1_q);
			end
			T_A2Q: begin
				a_op = feedback_a2_q;
				b_op = OPER_W'(hist_q2_q);
			end
			T_SUMQ: begin
				a_op = COEF_W'(sum3);
				b_op = OPER_W'(lb_q);
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
		case (chunk_q)
			2'd0:    b_sh = b_op;
			2'd1:    b_sh = b_op >>> CHUNK_W;
			default: b_sh = b_op >>> (2 * CHUNK_W);
		endcase
		// lower slices are unsigned, the top slice carries the sign
		if (chunk_last) begin
			b_chunk = b_sh[CHUNK_W:0];
		end else begin
			b_chunk = {1'b0, b_sh[CHUNK_W-1:0]};
		end
	end

	sqg_mac #(
		.ACC_W           (ACC_W),
		.COEF_FRAC_BITS  (COEF_FRAC_BITS),
		.STATE_FRAC_BITS (STATE_FRAC_BITS)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.a_op    (a_op),
		.b_chunk (b_chunk),
		.fin     (fin),
		.rnd     (rnd)
	);

	// saturate rounded sum to the history width
	always_comb begin
		rnd_upper = rnd[ACC_W-1:HIST_W-1];
		if (&rnd_upper || ~|rnd_upper) begin
			hist_new = rnd[HIST_W-1:0];
		end else if (rnd[ACC_W-1]) begin
			hist_new = {1'b1, {(HIST_W-1){1'b0}}};
		end else begin
			hist_new = {1'b0, {(HIST_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			term_q          <= T_LB;
			chunk_q         <= '0;
			out_valid_q     <= 1'b0;
			gain_b0_q       <= RST_GAIN_B0;
			feedback_a1_q   <= RST_FEEDBACK_A1;
			feedback_a2_q   <= RST_FEEDBACK_A2;
			half_omega_ts_q <= RST_HALF_OMEGA_TS;
			sample_q        <= '0;
			x1_q            <= '0;
			x2_q            <= '0;
			hist_i1_q       <= '0;
			hist_i2_q       <= '0;
			hist_q1_q       <= '0;
			hist_q2_q       <= '0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GAIN_B0:       gain_b0_q       <= cfg_data;
					CFG_FEEDBACK_A1:   feedback_a1_q   <= cfg_data;
					CFG_FEEDBACK_A2:   feedback_a2_q   <= cfg_data;
					CFG_HALF_OMEGA_TS: half_omega_ts_q <= cfg_data;
					default: ;
				endcase
			end

			if (in_xfer) begin
				sample_q <= sample;
				term_q   <= T_LB;
				chunk_q  <= '0;
			end else if (state_q == ST_RUN) begin
				if (chunk_last) begin
					chunk_q <= '0;
					term_q  <= term_next;
				end else begin
					chunk_q <= chunk_q + 2'd1;
				end
			end

			if (fin.valid) begin
				case (fin.tag)
					SUM_IP: begin
						hist_i1_q <= hist_new;
						hist_i2_q <= hist_i1_q;
					end
					SUM_QD: begin
						hist_q1_q <= hist_new;
						hist_q2_q <= hist_q1_q;
					end
					default: ;
				endcase
			end

			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
				x1_q        <= sample_q;
				x2_q        <= x1_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin.valid && fin.tag == SUM_LB) begin
			lb_q <= rnd[LB_W-1:0];
		end
		if (state_q == ST_DONE && out_free) begin
			in_phase_q   <= to_result(hist_i1_q);
			quadrature_q <= to_result(hist_q1_q);
		end
	end

endmodule

>>> tb/sv/sqg_result_checker.sv
`timescale 1ns / 1ps
// Result checker for sogi_quadrature_generator_unit: watches the sample, result and
// register write channels, predicts every result and compares it. Depends on sqg_pkg.
module sqg_result_checker #(
	parameter int SAMPLE_WIDTH    = 16,
	parameter int COEF_FRAC_BITS  = 29,
	parameter int STATE_FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic [SAMPLE_WIDTH-1:0]            sample,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic [sqg_pkg::RESULT_W-1:0]       in_phase,
	input  logic [sqg_pkg::RESULT_W-1:0]       quadrature,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [sqg_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [sqg_pkg::COEF_W-1:0]         cfg_data,
	output int                                 mismatch_count,
	output int                                 results_due
);
	import sqg_pkg::*;

	localparam logic signed [127:0] COEF_HALF = 128'sd1 <<< (COEF_FRAC_BITS - 1);
	localparam logic signed [127:0] HIST_MAX  = (128'sd1 <<< (HIST_W - 1)) - 128'sd1;
	localparam logic signed [127:0] HIST_MIN  = -(128'sd1 <<< (HIST_W - 1));
	localparam logic signed [63:0]  STATE_HALF = 64'sd1 <<< (STATE_FRAC_BITS - 1);
	localparam logic signed [63:0]  RES_MAX   = (64'sd1 <<< (RESULT_W - 1)) - 64'sd1;
	localparam logic signed [63:0]  RES_MIN   = -(64'sd1 <<< (RESULT_W - 1));

	typedef struct packed {
		logic signed [HIST_W-1:0] ip;
		logic signed [HIST_W-1:0] qd;
	} sogi_hist_t;

	typedef struct packed {
		logic signed [RESULT_W-1:0] ip;
		logic signed [RESULT_W-1:0] qd;
	} sogi_result_t;

	// coefficient copies and filter history
	logic signed [COEF_W-1:0]       gain_b0, fb_a1, fb_a2, half_wts;
	logic signed [SAMPLE_WIDTH-1:0] past_x [2];
	logic signed [HIST_W-1:0]       hist_ip [2];
	logic signed [HIST_W-1:0]       hist_qd [2];

	sogi_result_t pending_results [$];

	// exact sum at COEF+STATE fraction bits -> history word, ties toward +inf
	function automatic logic signed [HIST_W-1:0] hist_round(input logic signed [127:0] acc);
		logic signed [127:0] t;
		t = (acc + COEF_HALF) >>> COEF_FRAC_BITS;
		if (t > HIST_MAX)
			t = HIST_MAX;
		else if (t < HIST_MIN)
			t = HIST_MIN;
		return t[HIST_W-1:0];
	endfunction

	function automatic logic signed [RESULT_W-1:0] result_round(
		input logic signed [HIST_W-1:0] h
	);
		logic signed [63:0] t;
		t = 64'(h);
		t = (t + STATE_HALF) >>> STATE_FRAC_BITS;
		if (t > RES_MAX)
			t = RES_MAX;
		else if (t < RES_MIN)
			t = RES_MIN;
		return t[RESULT_W-1:0];
	endfunction

	function automatic sogi_hist_t sogi_advance(input logic signed [SAMPLE_WIDTH-1:0] x0);
		logic signed [127:0] s0, s1, s2, b0, a1, a2, lam, lb, acc;
		logic signed [127:0] i1, i2, q1, q2;
		sogi_hist_t nh;
		s0  = 128'(x0);
		s1  = 128'(past_x[0]);
		s2  = 128'(past_x[1]);
		b0  = 128'(gain_b0);
		a1  = 128'(fb_a1);
		a2  = 128'(fb_a2);
		lam = 128'(half_wts);
		i1  = 128'(hist_ip[0]);
		i2  = 128'(hist_ip[1]);
		q1  = 128'(hist_qd[0]);
		q2  = 128'(hist_qd[1]);
		acc = ((b0 * (s0 - s2)) <<< STATE_FRAC_BITS) + a1 * i1 + a2 * i2;
		nh.ip = hist_round(acc);
		// lamda*b0 back to coefficient scale first
		lb  = (lam * b0 + COEF_HALF) >>> COEF_FRAC_BITS;
		acc = ((lb * (s0 + (s1 <<< 1) + s2)) <<< STATE_FRAC_BITS) + a1 * q1 + a2 * q2;
		nh.qd = hist_round(acc);
		return nh;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		sogi_hist_t   nh;
		sogi_result_t exp_r;
		if (!arst_n) begin
			gain_b0        = RST_GAIN_B0;
			fb_a1          = RST_FEEDBACK_A1;
			fb_a2          = RST_FEEDBACK_A2;
			half_wts       = RST_HALF_OMEGA_TS;
			past_x[0]      = '0;
			past_x[1]      = '0;
			hist_ip[0]     = '0;
			hist_ip[1]     = '0;
			hist_qd[0]     = '0;
			hist_qd[1]     = '0;
			pending_results.delete();
			mismatch_count = 0;
			results_due    = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_GAIN_B0:       gain_b0  = cfg_data;
					CFG_FEEDBACK_A1:   fb_a1    = cfg_data;
					CFG_FEEDBACK_A2:   fb_a2    = cfg_data;
					CFG_HALF_OMEGA_TS: half_wts = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result transfer in_phase %0d quadrature %0d",
						$time, $signed(in_phase), $signed(quadrature));
					mismatch_count++;
				end else begin
					exp_r = pending_results.pop_front();
					if (exp_r.ip !== $signed(in_phase)) begin
						$display("%0t: in_phase expected %0d got %0d",
							$time, exp_r.ip, $signed(in_phase));
						mismatch_count++;
					end
					if (exp_r.qd !== $signed(quadrature)) begin
						$display("%0t: quadrature expected %0d got %0d",
							$time, exp_r.qd, $signed(quadrature));
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				nh = sogi_advance($signed(sample));
				past_x[1]  = past_x[0];
				past_x[0]  = $signed(sample);
				hist_ip[1] = hist_ip[0];
				hist_ip[0] = nh.ip;
				hist_qd[1] = hist_qd[0];
				hist_qd[0] = nh.qd;
				exp_r.ip = result_round(nh.ip);
				exp_r.qd = result_round(nh.qd);
				pending_results.push_back(exp_r);
			end
			results_due = pending_results.size();
		end
	end

endmodule

>>> tb/sv/tb_sogi_quadrature_generator_unit.sv
`timescale 1ns / 1ps
// Top of the sogi_quadrature_generator_unit testbench: clock, reset, sample and
// register stimulus, result back-pressure and verdict. Depends on sqg_pkg, sqg_result_checker.
module tb_sogi_quadrature_generator_unit;
	import sqg_pkg::*;

	localparam int  SAMPLE_WIDTH = 16;
	localparam real Q29          = 536870912.0;
	localparam real TWO_PI       = 6.283185307179586;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [SAMPLE_WIDTH-1:0] sample;
	logic                    out_valid;
	logic                    out_stall;
	logic [RESULT_W-1:0]     in_phase;
	logic [RESULT_W-1:0]     quadrature;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_INDEX_W-1:0]  cfg_index;
	logic [COEF_W-1:0]       cfg_data;

	int mismatch_count;
	int results_due;
	int samples_sent;
	bit idle_on;
	bit long_hold_done;

	sogi_quadrature_generator_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.in_phase   (in_phase),
		.quadrature (quadrature),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	sqg_result_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.in_phase       (in_phase),
		.quadrature     (quadrature),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly zero, sometimes a few cycles, rarely a long gap
	function automatic int idle_len();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(40, 20);
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic push_sample(input logic [SAMPLE_WIDTH-1:0] v);
		int gap;
		in_valid = 1'b1;
		sample   = v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		samples_sent++;
		@(negedge clk);
		gap = idle_on ? idle_len() : 0;
		if (gap != 0) begin
			in_valid = 1'b0;
			sample   = SAMPLE_WIDTH'($urandom);
			repeat (gap) @(negedge clk);
		end
	endtask

	// block idle: all results out, plus margin for the pipeline
	task automatic drain();
		in_valid = 1'b0;
		while (results_due != 0)
			@(negedge clk);
		repeat (25) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [COEF_W-1:0] v);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data  = $urandom;
	endtask

	task automatic load_coefs(input logic [COEF_W-1:0] b0, a1, a2, lam);
		drain();
		write_reg(CFG_GAIN_B0, b0);
		write_reg(CFG_FEEDBACK_A1, a1);
		write_reg(CFG_FEEDBACK_A2, a2);
		write_reg(CFG_HALF_OMEGA_TS, lam);
	endtask

	// Tustin SOGI coefficients for a random grid frequency, sample rate and damping
	task automatic pick_sogi(output logic [COEF_W-1:0] b0, a1, a2, lam, output real step);
		real w, ts, k, x, y, den;
		ts   = 1.0 / $urandom_range(40000, 5000);
		w    = TWO_PI * $urandom_range(400, 20);
		k    = 0.3 + $urandom_range(200) / 100.0;
		x    = 2.0 * k * w * ts;
		y    = w * ts * w * ts;
		den  = x + y + 4.0;
		b0   = $rtoi(x / den * Q29);
		a1   = $rtoi(2.0 * (4.0 - y) / den * Q29);
		a2   = $rtoi((x - y - 4.0) / den * Q29);
		lam  = $rtoi(w * ts / 2.0 * Q29);
		step = w * ts * (0.8 + $urandom_range(40) / 100.0);
	endtask

	function automatic logic [SAMPLE_WIDTH-1:0] clip_sample(input int v);
		if (v > 32767)
			return 16'h7fff;
		if (v < -32768)
			return 16'h8000;
		return v[SAMPLE_WIDTH-1:0];
	endfunction

	// receiver back-pressure, with one long hold while the sender keeps offering
	initial begin : rx_stall
		int n;
		out_stall      = 1'b0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && samples_sent >= 700) begin
				out_stall = 1'b1;
				repeat (400) @(negedge clk);
				long_hold_done = 1'b1;
				out_stall      = 1'b0;
			end else if (idle_on) begin
				n = idle_len();
				if (n != 0) begin
					out_stall = 1'b1;
					repeat (n) @(negedge clk);
					out_stall = 1'b0;
				end
			end
		end
	end

	initial begin : stimulus
		logic [COEF_W-1:0] b0, a1, a2, lam;
		real step, ph, amp;
		int  r, noise;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		sample       = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_GAIN_B0;
		cfg_data     = '0;
		samples_sent = 0;
		idle_on      = 1'b1;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset coefficients: full-scale steps and alternating bit patterns
		push_sample(16'h0000);
		push_sample(16'h7fff);
		push_sample(16'h7fff);
		push_sample(16'h8000);
		push_sample(16'h8000);
		push_sample(16'h0000);
		push_sample(16'h0001);
		push_sample(16'hffff);
		push_sample(16'h5555);
		push_sample(16'haaaa);

		// largest coefficients: drive history and results into saturation
		load_coefs(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		push_sample(16'h7fff);
		push_sample(16'h7fff);
		push_sample(16'h8000);

		load_coefs(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		push_sample(16'h8000);
		push_sample(16'h7fff);
		push_sample(16'h0000);

		// b0 = 0.5, lamda = 1.0, no feedback: exact halves hit round-half-up
		load_coefs(32'h10000000, 32'h00000000, 32'h00000000, 32'h20000000);
		push_sample(16'd3);
		push_sample(-16'sd3);
		push_sample(16'd1);
		push_sample(16'd0);

		for (int p = 0; p < 8; p++) begin
			pick_sogi(b0, a1, a2, lam, step);
			if (p % 4 == 3) begin
				b0  = $urandom;
				a1  = $urandom;
				a2  = $urandom;
				lam = $urandom;
			end else if (p == 6) begin
				lam = $urandom;
			end
			load_coefs(b0, a1, a2, lam);
			idle_on = (p != 2) && (p != 5);
			ph  = 0.0;
			amp = $urandom_range(40000, 100);
			for (int i = 0; i < 210; i++) begin
				if (p == 4 && i == 100) begin
					// sender waits for every outstanding result
					in_valid = 1'b0;
					while (results_due != 0)
						@(negedge clk);
				end
				r = $urandom_range(99);
				if (r < 70) begin
					noise = $urandom_range(400);
					push_sample(clip_sample($rtoi(amp * $sin(ph)) + noise - 200));
					ph = ph + step;
				end else if (r < 90) begin
					push_sample(SAMPLE_WIDTH'($urandom));
				end else if (r < 95) begin
					push_sample(r[0] ? 16'h7fff : 16'h8000);
				end else begin
					push_sample(clip_sample($urandom_range(8) - 4));
				end
			end
		end

		drain();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("tb_sogi_quadrature_generator_unit passed");
		else
			$display("tb_sogi_quadrature_generator_unit failed");
		$finish;
	end

	initial begin
		#8000000;
		$display("tb_sogi_quadrature_generator_unit failed");
		$finish;
	end

endmodule

>>> sim.f
design/sqg_pkg.sv
design/sqg_mac.sv
design/sogi_quadrature_generator_unit.sv
tb/sv/sqg_result_checker.sv
tb/sv/tb_sogi_quadrature_generator_unit.sv
